FILE: sv/ppu_pkg.sv
package ppu_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int FP_W            = 24;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam int GRP_MAX         = 10;
  localparam int PIX_MAX         = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'b1;

  typedef enum logic [1:0] {
    MODE_RAW16   = 2'd0,
    MODE_PACK10  = 2'd1,
    MODE_PACK12Q = 2'd2,
    MODE_PACK12P = 2'd3
  } mode_t;

  // one completed group, handed from the collector to the serialiser
  typedef struct packed {
    logic [PIX_MAX-1:0][15:0] pix;
    logic [3:0]               cnt;
    logic                     frame_end;
  } grp_t;

  function automatic logic [3:0] grp_len(mode_t mode);
    logic [3:0] len;
    case (mode)
      MODE_RAW16:   len = 4'd2;
      MODE_PACK10:  len = 4'd10;
      MODE_PACK12Q: len = 4'd6;
      MODE_PACK12P: len = 4'd3;
      default:      len = 4'd2;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] grp_pix(mode_t mode);
    logic [3:0] n;
    case (mode)
      MODE_RAW16:   n = 4'd1;
      MODE_PACK10:  n = 4'd8;
      MODE_PACK12Q: n = 4'd4;
      MODE_PACK12P: n = 4'd2;
      default:      n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: sv/ppu_if.sv
interface ppu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface ppu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        group_last;
  logic        frame_end;

  modport source(output valid, output pixel_value, output group_last, output frame_end,
                 input ready);
  modport sink(input valid, input pixel_value, input group_last, input frame_end,
               output ready);
endinterface

FILE: sv/packed_pixel_unpacker.sv
// Packed pixel unpacker.
// in_chan carries one frame byte per item (data_byte, frame_start); out_chan
// carries one 16-bit pixel per item with group_last and frame_end flags.
// Both channels use valid/ready; an item moves when both are high.
// cfg_we/cfg_index/cfg_wdata write format_mode (index 0) and frame_pixels
// (index 1); write them only while the block is idle.
// A byte is taken every cycle while in_chan.ready is high. The byte that
// closes a group loads all of its pixels into a group register at that edge;
// the first pixel is then registered in the output register and presented
// from there. Pixels leave one per cycle, while out_chan.ready stays high,
// from the group register through the output register.
// in_chan.ready drops only when the next byte would close a group while the
// previous group still has pixels left; with out_chan.ready held high this
// never happens in any mode. A stalled receiver holds the output register and
// the group register, and input backs up once the next group is due.
// Reset (rst_n low at a clock edge) clears the registers, group phase, pixel
// count and all pending pixels; the collected bytes are left as they were.
module packed_pixel_unpacker #(
  parameter int COUNT_WIDTH = ppu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ppu_in_if.sink                         in_chan,
  ppu_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic          grp_load;
  logic          g_free;
  ppu_pkg::grp_t grp;

  ppu_collect #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .g_free   (g_free),
    .grp_load (grp_load),
    .grp      (grp)
  );

  ppu_serial u_serial (
    .clk     (clk),
    .rst_n   (rst_n),
    .grp_load(grp_load),
    .grp     (grp),
    .g_free  (g_free),
    .out_chan(out_chan)
  );

endmodule

FILE: sv/ppu_collect.sv
module ppu_collect #(
  parameter int COUNT_WIDTH = ppu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ppu_in_if.sink                         in_chan,
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           g_free,
  output logic                           grp_load,
  output ppu_pkg::grp_t                  grp
);

  localparam int SW = ((COUNT_WIDTH > ppu_pkg::FP_W) ? COUNT_WIDTH : ppu_pkg::FP_W) + 1;

  ppu_pkg::mode_t           mode_r;
  logic [ppu_pkg::FP_W-1:0] fp_r;
  logic [7:0]               gb_r [ppu_pkg::GRP_MAX];
  logic [3:0]               phase_r;
  logic [COUNT_WIDTH-1:0]   cnt_r;

  logic [3:0]             glen, gpix, phase_hold, phase0, phase_eff;
  logic                   accept, fits, complete, last_frame;
  logic [COUNT_WIDTH-1:0] cnt0, new_cnt;
  logic [SW-1:0]          sum0, sum1;
  logic [7:0]             b [ppu_pkg::GRP_MAX];
  logic [15:0]            w;

  assign glen = ppu_pkg::grp_len(mode_r);
  assign gpix = ppu_pkg::grp_pix(mode_r);

  // stall only when the next item would close a group that cannot be handed on
  assign phase_hold    = (phase_r >= glen) ? 4'd0 : phase_r;
  assign in_chan.ready = g_free || (phase_hold != glen - 4'd1);
  assign accept        = in_chan.valid && in_chan.ready;

  assign phase0    = in_chan.frame_start ? 4'd0 : phase_r;
  assign phase_eff = (phase0 >= glen) ? 4'd0 : phase0;
  assign cnt0      = in_chan.frame_start ? '0 : cnt_r;

  assign sum0       = SW'(cnt0) + SW'(gpix);
  assign fits       = sum0 <= SW'(fp_r);
  assign complete   = fits && (phase_eff == glen - 4'd1);
  assign new_cnt    = sum0[COUNT_WIDTH-1:0];
  assign sum1       = SW'(new_cnt) + SW'(gpix);
  assign last_frame = sum1 > SW'(fp_r);

  assign grp_load = accept && complete;

  always_comb begin
    for (int k = 0; k < ppu_pkg::GRP_MAX; k++) begin
      b[k] = (phase_eff == 4'(k)) ? in_chan.data_byte : gb_r[k];
    end
    grp.pix       = '0;
    grp.cnt       = gpix;
    grp.frame_end = last_frame;
    w             = 16'd0;
    case (mode_r)
      ppu_pkg::MODE_RAW16: begin
        grp.pix[0] = {b[1], b[0]};
      end
      ppu_pkg::MODE_PACK10: begin
        w = {b[9], b[8]};
        for (int k = 0; k < 8; k++) begin
          grp.pix[k] = {b[k], w[2*k +: 2], 6'd0};
        end
      end
      ppu_pkg::MODE_PACK12Q: begin
        w = {b[5], b[4]};
        for (int k = 0; k < 4; k++) begin
          grp.pix[k] = {4'd0, b[k], w[4*k +: 4]};
        end
      end
      ppu_pkg::MODE_PACK12P: begin
        grp.pix[0] = {4'd0, b[0], b[2][3:0]};
        grp.pix[1] = {4'd0, b[1], b[2][7:4]};
      end
      default: begin
        grp.pix = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ppu_pkg::MODE_RAW16;
      fp_r    <= '0;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppu_pkg::REG_FORMAT_MODE:  mode_r <= ppu_pkg::mode_t'(cfg_wdata[1:0]);
          ppu_pkg::REG_FRAME_PIXELS: fp_r   <= cfg_wdata[ppu_pkg::FP_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!fits) begin
          // frame full: drop the item, keep the cleared phase and count
          phase_r <= phase_eff;
          cnt_r   <= cnt0;
        end else if (complete) begin
          phase_r <= 4'd0;
          cnt_r   <= new_cnt;
        end else begin
          phase_r <= phase_eff + 4'd1;
          cnt_r   <= cnt0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fits) begin
      gb_r[phase_eff] <= in_chan.data_byte;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < 4'(ppu_pkg::GRP_MAX))
    else $error("byte phase out of range");

  a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |=> (phase_r == 4'd0))
    else $error("phase not restarted after a completed group");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |-> g_free)
    else $error("group completed while the previous one still drains");

endmodule

FILE: sv/ppu_serial.sv
module ppu_serial (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_load,
  input  ppu_pkg::grp_t grp,
  output logic          g_free,
  ppu_out_if.source     out_chan
);

  ppu_pkg::grp_t g_r;
  logic          g_valid_r;
  logic [2:0]    idx_r;
  logic          out_valid_r;
  logic [15:0]   out_pixel_r;
  logic          out_last_r;
  logic          out_fend_r;

  logic pop, last;

  assign pop    = g_valid_r && (!out_valid_r || out_chan.ready);
  assign last   = idx_r == 3'(g_r.cnt - 4'd1);
  assign g_free = !g_valid_r || (pop && last);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pixel_r;
  assign out_chan.group_last  = out_last_r;
  assign out_chan.frame_end   = out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (grp_load) begin
        g_valid_r <= 1'b1;
        idx_r     <= '0;
      end else if (pop) begin
        idx_r <= idx_r + 3'd1;
        if (last) begin
          g_valid_r <= 1'b0;
        end
      end
      if (!out_valid_r || out_chan.ready) begin
        out_valid_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      g_r <= grp;
    end
    if (pop) begin
      out_pixel_r <= g_r.pix[idx_r];
      out_last_r  <= last;
      out_fend_r  <= last && g_r.frame_end;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_valid_r |-> (4'(idx_r) < g_r.cnt))
    else $error("pixel index beyond group size");

  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fend_r) |-> out_last_r)
    else $error("frame end flagged on a pixel that does not close its group");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && last && !grp_load) |=> !g_valid_r)
    else $error("group still held after its last pixel left");

endmodule
